// ===== sv/lidar_point_filter_macros.svh =====
// Assertion macros for the filter RTL.
`ifndef LIDAR_POINT_FILTER_MACROS_SVH
`define LIDAR_POINT_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define LPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lidar_point_filter: assertion failed");
`define LPF_ASSERT_NEXT(lbl, ante, cons) \
  `LPF_ASSERT(lbl, (ante) |=> (cons))
`else
`define LPF_ASSERT(lbl, prop)
`define LPF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/lpf_pkg.sv =====
package lpf_pkg;

  localparam int CNT_W = 48;
  localparam int OUT_W = 48;
  localparam int RNG_W = 20;
  localparam int SQ_W  = 2 * RNG_W;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [2:0]       reason_t;
  typedef logic [2:0]       cfg_index_t;

  localparam count_t CNT_MAX = '1;

  localparam reason_t RSN_KEPT   = 3'd0;
  localparam reason_t RSN_NO_RET = 3'd1;
  localparam reason_t RSN_TAG    = 3'd2;
  localparam reason_t RSN_REFL   = 3'd3;
  localparam reason_t RSN_RANGE  = 3'd4;

  localparam cfg_index_t CFG_ZERO_DROP    = 3'd0;
  localparam cfg_index_t CFG_TAG_MASK     = 3'd1;
  localparam cfg_index_t CFG_REFL_MIN     = 3'd2;
  localparam cfg_index_t CFG_MIN_RANGE_MM = 3'd3;
  localparam cfg_index_t CFG_MAX_RANGE_MM = 3'd4;

  typedef struct packed {
    logic            zero_drop;
    logic [7:0]      tag_mask;
    logic [7:0]      refl_min;
    logic [SQ_W-1:0] min_range_sq;
    logic [SQ_W-1:0] max_range_sq;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    reason_t reason;
  } verdict_t;

endpackage

// ===== sv/lpf_if.sv =====
interface lpf_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [7:0]         reflect;
  logic [7:0]         point_tag;

  modport source(output valid, coord_x, coord_y, coord_z, reflect, point_tag,
                 input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, reflect, point_tag,
               output ready);
endinterface

interface lpf_res_if;
  logic                      valid;
  logic                      ready;
  logic                      keep;
  logic [2:0]                reason;
  logic [lpf_pkg::OUT_W-1:0] count_seen;
  logic [lpf_pkg::OUT_W-1:0] count_kept;
  logic [lpf_pkg::OUT_W-1:0] count_no_return;
  logic [lpf_pkg::OUT_W-1:0] count_tag;
  logic [lpf_pkg::OUT_W-1:0] count_reflect;
  logic [lpf_pkg::OUT_W-1:0] count_range;

  modport source(output valid, keep, reason, count_seen, count_kept,
                 count_no_return, count_tag, count_reflect, count_range,
                 input ready);
  modport sink(input valid, keep, reason, count_seen, count_kept,
               count_no_return, count_tag, count_reflect, count_range,
               output ready);
endinterface

// ===== sv/lpf_cfg.sv =====
module lpf_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  lpf_pkg::cfg_index_t         cfg_index,
  input  logic [lpf_pkg::RNG_W-1:0]   cfg_wdata,
  output lpf_pkg::cfg_t               cfg
);

  logic [lpf_pkg::SQ_W-1:0] wdata_sq;

  assign wdata_sq = lpf_pkg::SQ_W'(cfg_wdata) * lpf_pkg::SQ_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpf_pkg::CFG_ZERO_DROP:    cfg.zero_drop    <= cfg_wdata[0];
        lpf_pkg::CFG_TAG_MASK:     cfg.tag_mask     <= cfg_wdata[7:0];
        lpf_pkg::CFG_REFL_MIN:     cfg.refl_min     <= cfg_wdata[7:0];
        lpf_pkg::CFG_MIN_RANGE_MM: cfg.min_range_sq <= wdata_sq;
        lpf_pkg::CFG_MAX_RANGE_MM: cfg.max_range_sq <= wdata_sq;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/lpf_pipe.sv =====
module lpf_pipe (
  input  logic                clk,
  input  logic                rst,
  input  lpf_pkg::cfg_t       cfg,
  lpf_pt_if.sink              pt_in,
  input  logic                take,
  output lpf_pkg::verdict_t   verdict
);

  logic               v1, v2, v3;
  logic               adv1, adv2, adv3;

  logic signed [31:0] x1, y1, z1;
  logic [7:0]         refl1, tag1;

  logic [31:0]        mag_x, mag_y, mag_z;
  lpf_pkg::reason_t   early_next;

  logic [63:0]        sq_x, sq_y, sq_z;
  lpf_pkg::reason_t   early2;

  logic [63:0]        sum_sq;
  logic               out_of_range;
  lpf_pkg::reason_t   reason_next;
  lpf_pkg::reason_t   reason3;

  assign adv3 = !v3 || take;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pt_in.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= pt_in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (adv1 && pt_in.valid) begin
      x1    <= pt_in.coord_x;
      y1    <= pt_in.coord_y;
      z1    <= pt_in.coord_z;
      refl1 <= pt_in.reflect;
      tag1  <= pt_in.point_tag;
    end
  end

  // stage 2: magnitudes, squares, early checks
  assign mag_x = x1[31] ? (~x1 + 32'd1) : x1;
  assign mag_y = y1[31] ? (~y1 + 32'd1) : y1;
  assign mag_z = z1[31] ? (~z1 + 32'd1) : z1;

  always_comb begin
    priority if (cfg.zero_drop && x1 == '0 && y1 == '0 && z1 == '0) begin
      early_next = lpf_pkg::RSN_NO_RET;
    end else if ((tag1 & cfg.tag_mask) != 8'd0) begin
      early_next = lpf_pkg::RSN_TAG;
    end else if (refl1 < cfg.refl_min) begin
      early_next = lpf_pkg::RSN_REFL;
    end else begin
      early_next = lpf_pkg::RSN_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      sq_x   <= 64'(mag_x) * 64'(mag_x);
      sq_y   <= 64'(mag_y) * 64'(mag_y);
      sq_z   <= 64'(mag_z) * 64'(mag_z);
      early2 <= early_next;
    end
  end

  // stage 3: range compare and final reason
  assign sum_sq = sq_x + sq_y + sq_z;
  assign out_of_range =
      (cfg.min_range_sq != '0 && sum_sq < 64'(cfg.min_range_sq)) ||
      (cfg.max_range_sq != '0 && sum_sq > 64'(cfg.max_range_sq));

  always_comb begin
    priority if (early2 != lpf_pkg::RSN_KEPT) begin
      reason_next = early2;
    end else if (out_of_range) begin
      reason_next = lpf_pkg::RSN_RANGE;
    end else begin
      reason_next = lpf_pkg::RSN_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      reason3 <= reason_next;
    end
  end

  assign verdict.valid  = v3;
  assign verdict.reason = reason3;

endmodule

// ===== sv/lpf_stats.sv =====
`include "lidar_point_filter_macros.svh"

module lpf_stats (
  input  logic                clk,
  input  logic                rst,
  input  lpf_pkg::verdict_t   verdict,
  output logic                take,
  lpf_res_if.source           res_out
);

  logic              out_valid;
  lpf_pkg::reason_t  reason_q;
  lpf_pkg::count_t   seen, kept, no_ret, tag, refl, range_cnt;
  logic              load;

  function automatic lpf_pkg::count_t sat_inc(input lpf_pkg::count_t c);
    return (c == lpf_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign take = !out_valid || res_out.ready;
  assign load = take && verdict.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seen      <= '0;
      kept      <= '0;
      no_ret    <= '0;
      tag       <= '0;
      refl      <= '0;
      range_cnt <= '0;
    end else if (take) begin
      out_valid <= verdict.valid;
      if (verdict.valid) begin
        seen <= sat_inc(seen);
        unique case (verdict.reason)
          lpf_pkg::RSN_KEPT:   kept   <= sat_inc(kept);
          lpf_pkg::RSN_NO_RET: no_ret <= sat_inc(no_ret);
          lpf_pkg::RSN_TAG:    tag    <= sat_inc(tag);
          lpf_pkg::RSN_REFL:   refl   <= sat_inc(refl);
          default:             range_cnt <= sat_inc(range_cnt);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reason_q <= verdict.reason;
    end
  end

  assign res_out.valid           = out_valid;
  assign res_out.keep            = (reason_q == lpf_pkg::RSN_KEPT);
  assign res_out.reason          = reason_q;
  assign res_out.count_seen      = lpf_pkg::OUT_W'(seen);
  assign res_out.count_kept      = lpf_pkg::OUT_W'(kept);
  assign res_out.count_no_return = lpf_pkg::OUT_W'(no_ret);
  assign res_out.count_tag       = lpf_pkg::OUT_W'(tag);
  assign res_out.count_reflect   = lpf_pkg::OUT_W'(refl);
  assign res_out.count_range     = lpf_pkg::OUT_W'(range_cnt);

  `LPF_ASSERT_NEXT(a_seen_step,
                   load && seen != lpf_pkg::CNT_MAX,
                   seen == $past(seen) + 1'b1)
  `LPF_ASSERT_NEXT(a_idle_hold, !load, $stable(seen) && $stable(kept) && $stable(range_cnt))
  `LPF_ASSERT_NEXT(a_kept_step,
                   load && verdict.reason == lpf_pkg::RSN_KEPT && kept != lpf_pkg::CNT_MAX,
                   kept == $past(kept) + 1'b1 && $stable(range_cnt))

endmodule

// ===== sv/lidar_point_filter.sv =====
// Lidar point filter: one point per clock in while res_out is not stalled,
// one verdict per point out; an accepted point passes the input register,
// squaring stage, range compare stage, then counter and result register;
// the three 32x32 squarers set the stage split. A point is
// dropped, first cause wins, for no return (all-zero coordinates while
// enabled), a tag bit hit by the reject mask, reflectivity below the minimum,
// or squared range outside the squared limits (a zero limit turns its side
// off). Every result carries the saturating counters as they stand after that
// point. Range limits are squared when written, so write configuration only
// with no point in flight.
module lidar_point_filter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  lpf_pkg::cfg_index_t       cfg_index,
  input  logic [lpf_pkg::RNG_W-1:0] cfg_wdata,
  lpf_pt_if.sink                    pt_in,
  lpf_res_if.source                 res_out
);

  lpf_pkg::cfg_t     cfg;
  lpf_pkg::verdict_t verdict;
  logic              take;

  lpf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpf_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pt_in   (pt_in),
    .take    (take),
    .verdict (verdict)
  );

  lpf_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .verdict (verdict),
    .take    (take),
    .res_out (res_out)
  );

endmodule
